/* hw/rtl/cma_pkg.sv */
package cma_pkg;

    localparam int X_BITS      = 32;
    localparam int SAMPLE_BITS = 24;
    localparam int RADIUS_BITS = 5;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_RADIUS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXCLUDE_CENTER = 1'b1;

    localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 5'd2;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CHECK = 6'b000010,
        ST_READ  = 6'b000100,
        ST_ACC   = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_OUT   = 6'b100000
    } cma_state_t;

endpackage

/* hw/rtl/cma_in_if.sv */
interface cma_in_if;
    import cma_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [X_BITS-1:0]      x_coord;
    logic signed [SAMPLE_BITS-1:0] sample_value;
    logic                          is_last;

    modport source (output valid, x_coord, sample_value, is_last, input ready);
    modport sink (input valid, x_coord, sample_value, is_last, output ready);
endinterface

/* hw/rtl/cma_out_if.sv */
interface cma_out_if;
    import cma_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [X_BITS-1:0]      x_out;
    logic signed [SAMPLE_BITS-1:0] average_value;
    logic                          last_out;

    modport source (output valid, x_out, average_value, last_out, input ready);
    modport sink (input valid, x_out, average_value, last_out, output ready);
endinterface

/* hw/rtl/cma_cfg_if.sv */
interface cma_cfg_if;
    import cma_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/cma_ring.sv */
module cma_ring #(
    parameter int DEPTH = 64,
    parameter int SW    = 24,
    parameter int XW    = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [SW-1:0]            wsample,
    input  logic [XW-1:0]            wx,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [SW-1:0]            rsample,
    output logic [XW-1:0]            rx
);
    logic [SW-1:0] sample_mem [DEPTH];
    logic [XW-1:0] x_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            sample_mem[waddr] <= wsample;
            x_mem[waddr]      <= wx;
        end
        rsample <= sample_mem[raddr];
        rx      <= x_mem[raddr];
    end
endmodule

/* hw/rtl/cma_div.sv */
module cma_div #(
    parameter int NW = 32,
    parameter int DW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] numer,
    input  logic [DW-1:0] denom,
    output logic          done,
    output logic [NW-1:0] quot
);
    localparam int CNTW = $clog2(NW + 1);

    logic [DW-1:0]   rem_reg, rem_next;
    logic [NW-1:0]   q_reg, q_next;
    logic [DW-1:0]   d_reg;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            run_reg, run_next;
    logic            done_reg, done_next;
    logic [DW:0]     shifted;
    logic            fits;

    assign shifted = {rem_reg, q_reg[NW-1]};
    assign fits    = shifted >= {1'b0, d_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next = '0;
            q_next   = numer;
            cnt_next = CNTW'(NW);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = fits ? DW'(shifted - {1'b0, d_reg}) : shifted[DW-1:0];
            q_next   = {q_reg[NW-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNTW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        if (start)
            d_reg <= denom;
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule

/* hw/rtl/centered_moving_average_top.sv */
// centered moving average with windows that shrink at the sequence edges
// in_ch takes points (x_coord, sample_value, is_last); out_ch gives one
// smoothed point per input point, in input order, with the same x.
// cfg_ch writes window_radius (index 0) and exclude_center (index 1); it is
// always ready, and the user must write it only while the block is idle;
// the block itself does not enforce this. one request is taken at a time:
// after a request the block emits every point whose window is complete
// (all pending points when is_last is set), then returns ready.
// for each emitted point the window terms are read from the ring memory
// (one read port, registered read) in a read and an accumulate state per
// term, the quotient comes from the bit-serial divider, and a check state
// and an output state handle control.
// a request that releases no point returns from the check state to idle.
// the result sits in an output register until out_ch takes it; a stalled
// receiver holds the block in that state.
// reset clears pointers, point count and configuration (radius 2, center
// included); the ring memory is not cleared and needs no clearing pass.
module centered_moving_average_top #(
    parameter int MAX_RADIUS  = 31,
    parameter int RING_DEPTH  = 64
) (
    input  logic    clk,
    input  logic    rst_n,
    cma_in_if.sink  in_ch,
    cma_out_if.source out_ch,
    cma_cfg_if.sink cfg_ch
);
    import cma_pkg::*;

    localparam int RC  = (MAX_RADIUS < (RING_DEPTH - 1) / 2) ? MAX_RADIUS
                                                             : (RING_DEPTH - 1) / 2;
    localparam int PW  = $clog2(RING_DEPTH);
    localparam int PX  = PW + 1;
    localparam int PSW = $clog2(RING_DEPTH + 1);
    localparam int RW  = $clog2(RC + 1);
    localparam int CW  = $clog2(2 * RC + 2);
    localparam int SW  = SAMPLE_BITS + CW;

    cma_state_t state_reg, state_next;

    logic [RADIUS_BITS-1:0] radius_cfg_reg;
    logic                   excl_reg;
    logic [PW-1:0]          wp_reg, wp_next;
    logic [PW-1:0]          ne_reg, ne_next;
    logic [PSW-1:0]         ps_reg, ps_next;
    logic                   last_reg, last_next;
    logic [RW-1:0]          r_reg, r_next;
    logic [CW-1:0]          k_reg, k_next;
    logic [PW-1:0]          rp_reg, rp_next;
    logic signed [SW-1:0]   sum_reg, sum_next;
    logic                   flag_reg, flag_next;
    logic                   neg_reg, neg_next;
    logic [X_BITS-1:0]      xh_reg, xh_next;
    logic [X_BITS-1:0]      ox_reg;
    logic [SAMPLE_BITS-1:0] oavg_reg;
    logic                   olast_reg;

    logic [RW-1:0]          radius;
    logic [PX-1:0]          pending;
    logic [PX-1:0]          after;
    logic [PX-1:0]          prior;
    logic [PX-1:0]          rmin;
    logic [PX-1:0]          start_ix;
    logic                   in_acc;
    logic [SAMPLE_BITS-1:0] rd_sample;
    logic [X_BITS-1:0]      rd_x;
    logic signed [SW-1:0]   sum_add;
    logic                   skip;
    logic                   div_start;
    logic [SW-1:0]          div_numer;
    logic [CW-1:0]          div_denom;
    logic                   div_done;
    logic [SW-1:0]          div_quot;
    logic [SAMPLE_BITS-1:0] q_trunc;

    assign radius = ({27'b0, radius_cfg_reg} > 32'(RC)) ? RW'(RC) : RW'(radius_cfg_reg);

    always_comb
    begin
        if (wp_reg >= ne_reg)
            pending = PX'(wp_reg) - PX'(ne_reg);
        else
            pending = PX'(wp_reg) + PX'(RING_DEPTH) - PX'(ne_reg);
        after  = pending - 1'b1;
        prior  = (PX'(ps_reg) > pending) ? PX'(ps_reg) - pending : '0;
        rmin   = PX'(radius);
        if (prior < rmin)
            rmin = prior;
        if (after < rmin)
            rmin = after;
        if (PX'(ne_reg) >= rmin)
            start_ix = PX'(ne_reg) - rmin;
        else
            start_ix = PX'(ne_reg) + PX'(RING_DEPTH) - rmin;
    end

    assign in_ch.ready  = state_reg == ST_IDLE;
    assign cfg_ch.ready = 1'b1;
    assign in_acc       = in_ch.valid && in_ch.ready;

    cma_ring #(
        .DEPTH(RING_DEPTH),
        .SW   (SAMPLE_BITS),
        .XW   (X_BITS)
    ) u_ring (
        .clk    (clk),
        .we     (in_acc),
        .waddr  (wp_reg),
        .wsample(in_ch.sample_value),
        .wx     (in_ch.x_coord),
        .raddr  (rp_reg),
        .rsample(rd_sample),
        .rx     (rd_x)
    );

    assign skip    = excl_reg && (r_reg != '0) && (k_reg == CW'(r_reg));
    assign sum_add = sum_reg + {{CW{rd_sample[SAMPLE_BITS-1]}}, rd_sample};

    always_comb
    begin
        state_next = state_reg;
        wp_next    = wp_reg;
        ne_next    = ne_reg;
        ps_next    = ps_reg;
        last_next  = last_reg;
        r_next     = r_reg;
        k_next     = k_reg;
        rp_next    = rp_reg;
        sum_next   = sum_reg;
        flag_next  = flag_reg;
        neg_next   = neg_reg;
        xh_next    = xh_reg;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    wp_next   = (wp_reg == PW'(RING_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                    ps_next   = (ps_reg == PSW'(RING_DEPTH)) ? ps_reg : ps_reg + 1'b1;
                    last_next = in_ch.is_last;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (pending == '0 || (!last_reg && after < PX'(radius)))
                begin
                    if (last_reg)
                        ps_next = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    r_next     = RW'(rmin);
                    k_next     = '0;
                    rp_next    = PW'(start_ix);
                    sum_next   = '0;
                    flag_next  = last_reg && (pending == PX'(1));
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (!skip)
                    sum_next = sum_add;
                if (k_reg == CW'(r_reg))
                    xh_next = rd_x;
                if (k_reg == {r_reg, 1'b0})
                begin
                    div_start  = 1'b1;
                    neg_next   = sum_next[SW-1];
                    state_next = ST_DIV;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    rp_next    = (rp_reg == PW'(RING_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ch.ready)
                begin
                    ne_next    = (ne_reg == PW'(RING_DEPTH - 1)) ? '0 : ne_reg + 1'b1;
                    state_next = ST_CHECK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign div_numer = sum_next[SW-1] ? SW'(-sum_next) : SW'(sum_next);
    assign div_denom = (excl_reg && r_reg != '0) ? {r_reg, 1'b0} : {r_reg, 1'b1};

    cma_div #(
        .NW(SW),
        .DW(CW)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .numer(div_numer),
        .denom(div_denom),
        .done (div_done),
        .quot (div_quot)
    );

    assign q_trunc = neg_reg ? SAMPLE_BITS'(-div_quot) : SAMPLE_BITS'(div_quot);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            radius_cfg_reg <= RADIUS_RESET;
            excl_reg       <= 1'b0;
            wp_reg         <= '0;
            ne_reg         <= '0;
            ps_reg         <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            ne_reg    <= ne_next;
            ps_reg    <= ps_next;
            last_reg  <= last_next;
            if (cfg_ch.valid)
            begin
                case (cfg_ch.index)
                    CFG_WINDOW_RADIUS:  radius_cfg_reg <= cfg_ch.data;
                    CFG_EXCLUDE_CENTER: excl_reg       <= cfg_ch.data[0];
                    default:            excl_reg       <= excl_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg    <= r_next;
        k_reg    <= k_next;
        rp_reg   <= rp_next;
        sum_reg  <= sum_next;
        flag_reg <= flag_next;
        neg_reg  <= neg_next;
        xh_reg   <= xh_next;
        if (state_reg == ST_DIV && div_done)
        begin
            ox_reg    <= xh_reg;
            oavg_reg  <= q_trunc;
            olast_reg <= flag_reg;
        end
    end

    assign out_ch.valid         = state_reg == ST_OUT;
    assign out_ch.x_out         = ox_reg;
    assign out_ch.average_value = oavg_reg;
    assign out_ch.last_out      = olast_reg;
endmodule

/* bench/cma_smoothing_checker.sv */
`timescale 1ns / 1ps

module cma_smoothing_checker (
    input  logic        clk,
    input  logic        rst_n,
    cma_in_if           in_mon,
    cma_out_if          out_mon,
    cma_cfg_if          cfg_mon,
    output int          mismatch_count,
    output int          smoothed_outstanding,
    output int          smoothed_seen
);
    import cma_pkg::*;

    localparam int DEPTH = 64;
    localparam int RADIUS_CAP = 31;

    typedef struct {
        logic signed [X_BITS-1:0] x;
        logic signed [23:0]       avg;
        logic                     lst;
    } smoothed_point_t;

    smoothed_point_t smoothed_q[$];

    logic signed [23:0]       y_hist[DEPTH];
    logic signed [X_BITS-1:0] x_hist[DEPTH];
    int                       seq_count;
    int                       oldest_slot;
    int                       fill_slot;
    logic [RADIUS_BITS-1:0]   radius_reg;
    logic                     drop_center;

    task automatic smooth_point(input logic signed [X_BITS-1:0] xv,
                                input logic signed [23:0] yv, input logic lastv);
        int              waiting;
        int              later;
        int              earlier;
        int              half;
        int              radius_use;
        int              divisor;
        longint          acc;
        smoothed_point_t p;
        radius_use = (radius_reg > RADIUS_CAP) ? RADIUS_CAP : int'(radius_reg);
        y_hist[fill_slot] = yv;
        x_hist[fill_slot] = xv;
        fill_slot = (fill_slot + 1) % DEPTH;
        if (seq_count < DEPTH)
            seq_count++;
        forever
        begin
            waiting = (fill_slot + DEPTH - oldest_slot) % DEPTH;
            if (waiting == 0)
                break;
            later = waiting - 1;
            if (!lastv && later < radius_use)
                break;
            earlier = (seq_count > waiting) ? seq_count - waiting : 0;
            half = radius_use;
            if (earlier < half)
                half = earlier;
            if (later < half)
                half = later;
            acc = 0;
            for (int k = -half; k <= half; k++)
            begin
                if (k == 0 && drop_center && half != 0)
                    continue;
                acc += longint'(y_hist[(oldest_slot + k + DEPTH) % DEPTH]);
            end
            divisor = (drop_center && half != 0) ? 2 * half : 2 * half + 1;
            p.x = x_hist[oldest_slot];
            p.avg = 24'(acc / longint'(divisor));
            p.lst = lastv && (waiting == 1);
            smoothed_q = {smoothed_q, p};
            oldest_slot = (oldest_slot + 1) % DEPTH;
        end
        if (lastv)
            seq_count = 0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smoothed_q.delete();
            seq_count = 0;
            oldest_slot = 0;
            fill_slot = 0;
            radius_reg = RADIUS_RESET;
            drop_center = 1'b0;
            mismatch_count = 0;
            smoothed_seen = 0;
        end
        else
        begin
            if (cfg_mon.valid && cfg_mon.ready)
            begin
                if (cfg_mon.index == CFG_WINDOW_RADIUS)
                    radius_reg = cfg_mon.data[RADIUS_BITS-1:0];
                else if (cfg_mon.index == CFG_EXCLUDE_CENTER)
                    drop_center = cfg_mon.data[0];
            end
            if (in_mon.valid && in_mon.ready)
                smooth_point(in_mon.x_coord, in_mon.sample_value, in_mon.is_last);
            if (out_mon.valid && out_mon.ready)
            begin
                smoothed_point_t e;
                smoothed_seen++;
                if (smoothed_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: x=%0d avg=%0d last=%0b",
                                 out_mon.x_out, out_mon.average_value, out_mon.last_out);
                end
                else
                begin
                    e = smoothed_q.pop_front();
                    if (out_mon.x_out !== e.x || out_mon.average_value !== e.avg
                        || out_mon.last_out !== e.lst)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"mismatch: exp x=%0d avg=%0d last=%0b, ",
                                      "got x=%0d avg=%0d last=%0b"},
                                     e.x, e.avg, e.lst, out_mon.x_out,
                                     out_mon.average_value, out_mon.last_out);
                    end
                end
            end
        end
        smoothed_outstanding = smoothed_q.size();
    end

endmodule

/* bench/tb_centered_moving_average_top.sv */
`timescale 1ns / 1ps

module tb_centered_moving_average_top;
    import cma_pkg::*;

    logic clk;
    logic rst_n;
    int   mismatch_count;
    int   smoothed_outstanding;
    int   smoothed_seen;
    int   points_sent;
    int   reg_writes;
    int   seq_left;
    bit   stall_done;

    cma_in_if  in_ch ();
    cma_out_if out_ch ();
    cma_cfg_if cfg_ch ();

    centered_moving_average_top DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    cma_smoothing_checker u_checker (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_mon               (in_ch),
        .out_mon              (out_ch),
        .cfg_mon              (cfg_ch),
        .mismatch_count       (mismatch_count),
        .smoothed_outstanding (smoothed_outstanding),
        .smoothed_seen        (smoothed_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("timeout");
        $display("Verification failed");
        $finish;
    end

    task automatic send_point(input logic signed [31:0] xv, input logic signed [23:0] yv,
                              input logic lastv, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.x_coord      <= xv;
        in_ch.sample_value <= yv;
        in_ch.is_last      <= lastv;
        do
            @(negedge clk);
        while (!in_ch.ready);
        @(posedge clk);
        points_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(negedge clk);
        while (!cfg_ch.ready);
        @(posedge clk);
        reg_writes++;
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (smoothed_outstanding != 0)
            @(negedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic random_point(input bit no_gap);
        logic signed [23:0] yv;
        logic               lastv;
        if (seq_left == 0)
            seq_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 12);
        case ($urandom_range(0, 5))
            0: yv = 24'sh800000;
            1: yv = 24'sh7fffff;
            2: yv = 24'($signed($urandom_range(0, 200)) - 100);
            default: yv = 24'($urandom());
        endcase
        lastv = (seq_left == 1);
        seq_left--;
        send_point(32'($urandom()), yv, lastv, no_gap);
    endtask

    // receiver with random stalls and one long hold-off
    initial
    begin
        int w;
        out_ch.ready <= 1'b0;
        stall_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            w = (smoothed_seen >= 60 && smoothed_seen < 90) ? 0 : $urandom_range(0, 4);
            if (!stall_done && smoothed_seen >= 30)
            begin
                stall_done = 1'b1;
                w = 600;
            end
            if (w > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(negedge clk);
            while (!out_ch.valid);
            @(posedge clk);
        end
    end

    initial
    begin
        logic [RADIUS_BITS-1:0] rad_set[6];
        logic                   exc_set[6];
        rad_set = '{5'd0, 5'd0, 5'd31, 5'd31, 5'd1, 5'd5};
        exc_set = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
        points_sent = 0;
        reg_writes = 0;
        seq_left = 0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.x_coord = '0;
        in_ch.sample_value = '0;
        in_ch.is_last = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_WINDOW_RADIUS;
        cfg_ch.data = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // two single-point sequences, then short sequences, most at field extremes
        send_point(32'sh7fffffff, 24'sh7fffff, 1'b1, 1'b0);
        send_point(32'sh80000000, 24'sh800000, 1'b1, 1'b0);
        send_point(32'sh80000000, 24'sh800000, 1'b0, 1'b0);
        send_point(32'sh7fffffff, 24'sh800000, 1'b0, 1'b0);
        send_point(-32'sd1, 24'sh800000, 1'b0, 1'b0);
        send_point(32'sd0, 24'sh800000, 1'b0, 1'b0);
        send_point(32'sd1, 24'sh800000, 1'b1, 1'b0);
        for (int i = 0; i < 8; i++)
            send_point(32'(i * 1000 - 3), (i % 2) ? 24'sh7fffff : 24'sh800000,
                       i == 7, 1'b1);
        send_point(32'sd5, 24'sh000001, 1'b0, 1'b0);
        send_point(32'sd6, -24'sd2, 1'b0, 1'b0);
        send_point(32'sd7, 24'sh000003, 1'b1, 1'b0);

        for (int ph = 0; ph < 7; ph++)
        begin
            wait_idle();
            if (ph < 6)
            begin
                write_reg(CFG_WINDOW_RADIUS, CFG_DATA_W'(rad_set[ph]));
                write_reg(CFG_EXCLUDE_CENTER, CFG_DATA_W'(exc_set[ph]));
            end
            else
            begin
                write_reg(CFG_WINDOW_RADIUS, CFG_DATA_W'($urandom_range(0, 31)));
                write_reg(CFG_EXCLUDE_CENTER, CFG_DATA_W'($urandom_range(0, 1)));
            end
            cfg_ch.valid <= 1'b0;
            for (int i = 0; i < 30; i++)
                random_point(ph == 2 && i < 12);
        end
        if (seq_left != 0)
        begin
            seq_left = 1;
            random_point(1'b0);
        end

        in_ch.valid <= 1'b0;
        @(negedge clk);
        while (smoothed_outstanding != 0)
            @(negedge clk);
        repeat (300) @(posedge clk);

        $display("sent %0d points and %0d register writes, %0d smoothed points checked",
                 points_sent, reg_writes, smoothed_seen);
        $display("radius 0 to 31 with center kept and dropped, one long output stall");
        if (mismatch_count == 0 && smoothed_outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
